@@ hw/rtl/trilinear_grid_sampler_macros.svh @@
// Assertion macros shared by the trilinear grid sampler RTL.
`ifndef TRILINEAR_GRID_SAMPLER_MACROS_SVH
`define TRILINEAR_GRID_SAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check cons in the same cycle as ante.
`define TGS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgs assertion failed");
// Check cons in the cycle after ante.
`define TGS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgs assertion failed");
`else
`define TGS_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define TGS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/tgs_pkg.sv @@
// Types and constants shared by the trilinear grid sampler modules.
package tgs_pkg;

    localparam int DATA_W      = 32;
    localparam int CELL_ADDR_W = 15;
    localparam int IDX_W       = 8;
    localparam int WGT_W       = 16;
    localparam int OPND_W      = 33;
    localparam int PROD_W      = 66;
    localparam int QUEUE_DEPTH = 8;
    localparam int APB_ADDR_W  = 4;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [1:0] REG_OFFSET_X      = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y      = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z      = 2'd2;
    localparam logic [1:0] REG_INV_CELL_SIZE = 2'd3;

    localparam logic [DATA_W-1:0] INV_CELL_RESET = 32'h0001_0000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] LAST_CORNER = 3'd7;
    localparam logic [2:0] LAST_STEP   = 3'd6;
    localparam logic [2:0] FIRST_Y_STEP = 3'd4;

    typedef struct packed {
        logic                     req_type;
        logic [CELL_ADDR_W-1:0]   cell_address;
        logic signed [DATA_W-1:0] cell_value;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     out_of_range;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] offset_x;
        logic signed [DATA_W-1:0] offset_y;
        logic signed [DATA_W-1:0] offset_z;
        logic [DATA_W-1:0]        inv_cell_size;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX_MUL,
        ST_AX_CHK,
        ST_ROW_MUL,
        ST_ROW_ADD,
        ST_BASE_MUL,
        ST_BASE_ADD,
        ST_FETCH,
        ST_DRAIN,
        ST_LERP_SUB,
        ST_LERP_MUL,
        ST_LERP_ADD
    } state_t;

endpackage

@@ hw/rtl/trilinear_grid_sampler.sv @@
// Top level of the trilinear grid sampler: sequencer, corner queue and glue.
//
// Usage:
//   Items enter on req when start is high and busy is low. A write item
//   (req_type 0) stores cell_value at cell_address in the grid memory at that
//   same edge; addresses at or beyond GRID_X*GRID_Y*GRID_Z are dropped. A
//   write produces no result and the next item may follow in the next cycle.
//   A sample item (req_type 1) raises busy. One 33x33 multiplier is shared
//   for the three axis scalings, the two address products and the seven
//   blends; the single-port grid memory delivers the eight corners one per
//   cycle. An in-range sample passes the axis, address, fetch and blend
//   states before done rises, an out-of-range one ends after the axis checks;
//   busy falls in the cycle done is high, so a new item may be taken then.
//   done marks result for exactly one cycle; the receiver cannot stall it.
//   Configuration goes through the APB port (offsets at 0x0, 0x4, 0x8,
//   inverse cell size at 0xC) and must only be written while idle.
//   Reset clears the sequencer and the registers to their reset values; the
//   grid memory is not cleared and holds nothing defined until written.
`include "trilinear_grid_sampler_macros.svh"

module trilinear_grid_sampler #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tgs_pkg::req_t                   req,
    output logic                            done,
    output tgs_pkg::rsp_t                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tgs_pkg::DATA_W-1:0]      pwdata,
    output logic [tgs_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import tgs_pkg::*;

    localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
    localparam int ADDR_W = $clog2(CELLS);

    // Linear distance of a neighbor along each axis.
    localparam logic [ADDR_W-1:0] STEP_Z = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] STEP_Y = ADDR_W'(GRID_Z);
    localparam logic [ADDR_W-1:0] STEP_X = ADDR_W'(GRID_Y * GRID_Z);

    // Highest legal base index per axis.
    localparam logic [DATA_W-1:0] LIM_X = DATA_W'(GRID_X - 2);
    localparam logic [DATA_W-1:0] LIM_Y = DATA_W'(GRID_Y - 2);
    localparam logic [DATA_W-1:0] LIM_Z = DATA_W'(GRID_Z - 2);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic signed [OPND_W-1:0] s_reg   [0:2];
    logic [IDX_W-1:0]         idx_reg [0:2];
    logic [WGT_W-1:0]         wgt_reg [0:2];
    logic [1:0]               ax_reg;
    logic                     ok_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [2:0]               fcnt_reg;
    logic [2:0]               step_reg;
    logic                     rd_pend_reg;
    logic signed [DATA_W-1:0] q_reg [0:QUEUE_DEPTH-1];
    logic [3:0]               qcnt_reg;
    logic signed [OPND_W-1:0] diff_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic                     done_reg;
    rsp_t                     result_reg;

    logic                     accept;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [ADDR_W-1:0]        corner_ofs;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [DATA_W-1:0]        lim_sel;
    logic                     ax_ok;
    logic [WGT_W-1:0]         wgt_sel;
    logic signed [PROD_W-1:0] blend_sum;
    logic signed [DATA_W-1:0] blend_res;

    tgs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgs_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    tgs_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req.cell_value),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign ram_we = accept && (req.req_type == REQ_WRITE)
                    && (32'(req.cell_address) < 32'(CELLS));

    // Corner order: z fastest, then y, then x, so blend pairs sit side by side.
    always_comb
    begin
        corner_ofs = '0;
        if (fcnt_reg[0])
        begin
            corner_ofs = corner_ofs + STEP_Z;
        end
        if (fcnt_reg[1])
        begin
            corner_ofs = corner_ofs + STEP_Y;
        end
        if (fcnt_reg[2])
        begin
            corner_ofs = corner_ofs + STEP_X;
        end
    end

    assign ram_addr = ram_we ? ADDR_W'(req.cell_address) : (base_reg + corner_ofs);

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_ROW_MUL:
            begin
                mul_a = {{(OPND_W-IDX_W){1'b0}}, idx_reg[AXIS_X]};
                mul_b = OPND_W'(GRID_Y);
            end
            ST_BASE_MUL:
            begin
                mul_a = {{(OPND_W-ADDR_W){1'b0}}, base_reg};
                mul_b = OPND_W'(GRID_Z);
            end
            ST_LERP_MUL:
            begin
                mul_a = diff_reg;
                mul_b = {{(OPND_W-WGT_W){1'b0}}, wgt_sel};
            end
            default:
            begin
                mul_a = s_reg[ax_reg];
                mul_b = {1'b0, cfg.inv_cell_size};
            end
        endcase
    end

    always_comb
    begin
        case (ax_reg)
            AXIS_X:  lim_sel = LIM_X;
            AXIS_Y:  lim_sel = LIM_Y;
            default: lim_sel = LIM_Z;
        endcase
    end

    // Index is the integer part of the Q32.32 product; negative shifts fail.
    assign ax_ok = !s_reg[ax_reg][OPND_W-1] && (prod[63:32] <= lim_sel);

    // Blend along z first, then y, then x.
    always_comb
    begin
        if (step_reg < FIRST_Y_STEP)
        begin
            wgt_sel = wgt_reg[AXIS_Z];
        end
        else if (step_reg < LAST_STEP)
        begin
            wgt_sel = wgt_reg[AXIS_Y];
        end
        else
        begin
            wgt_sel = wgt_reg[AXIS_X];
        end
    end

    // lo + round((hi - lo) * w / 2^16), ties up, as one add before the shift.
    assign blend_sum = prod + {{(PROD_W-DATA_W-WGT_W){lo_reg[DATA_W-1]}}, lo_reg, 16'h8000};
    assign blend_res = blend_sum[DATA_W+WGT_W-1:WGT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == REQ_SAMPLE))
                begin
                    state_next = ST_AX_MUL;
                end
            end
            ST_AX_MUL:   state_next = ST_AX_CHK;
            ST_AX_CHK:
            begin
                if (ax_reg != AXIS_Z)
                begin
                    state_next = ST_AX_MUL;
                end
                else if (ok_reg && ax_ok)
                begin
                    state_next = ST_ROW_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_MUL:  state_next = ST_ROW_ADD;
            ST_ROW_ADD:  state_next = ST_BASE_MUL;
            ST_BASE_MUL: state_next = ST_BASE_ADD;
            ST_BASE_ADD: state_next = ST_FETCH;
            ST_FETCH:
            begin
                if (fcnt_reg == LAST_CORNER)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:    state_next = ST_LERP_SUB;
            ST_LERP_SUB: state_next = ST_LERP_MUL;
            ST_LERP_MUL: state_next = ST_LERP_ADD;
            ST_LERP_ADD:
            begin
                state_next = (step_reg == LAST_STEP) ? ST_IDLE : ST_LERP_SUB;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control counters and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg      <= AXIS_X;
            ok_reg      <= 1'b0;
            fcnt_reg    <= '0;
            step_reg    <= '0;
            rd_pend_reg <= 1'b0;
            qcnt_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            rd_pend_reg <= (state_reg == ST_FETCH);
            if (rd_pend_reg)
            begin
                qcnt_reg <= qcnt_reg + 4'd1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    ax_reg   <= AXIS_X;
                    ok_reg   <= 1'b1;
                    fcnt_reg <= '0;
                    step_reg <= '0;
                    qcnt_reg <= '0;
                end
                ST_AX_CHK:
                begin
                    ok_reg <= ok_reg && ax_ok;
                    ax_reg <= ax_reg + 2'd1;
                    if ((ax_reg == AXIS_Z) && !(ok_reg && ax_ok))
                    begin
                        done_reg <= 1'b1;
                    end
                end
                ST_FETCH:
                begin
                    fcnt_reg <= fcnt_reg + 3'd1;
                end
                ST_LERP_SUB:
                begin
                    qcnt_reg <= qcnt_reg - 4'd2;
                end
                ST_LERP_ADD:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        qcnt_reg <= qcnt_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg[AXIS_X] <= $signed({req.pos_x[DATA_W-1], req.pos_x})
                           - $signed({cfg.offset_x[DATA_W-1], cfg.offset_x});
            s_reg[AXIS_Y] <= $signed({req.pos_y[DATA_W-1], req.pos_y})
                           - $signed({cfg.offset_y[DATA_W-1], cfg.offset_y});
            s_reg[AXIS_Z] <= $signed({req.pos_z[DATA_W-1], req.pos_z})
                           - $signed({cfg.offset_z[DATA_W-1], cfg.offset_z});
        end

        // Push a fetched corner at the tail of the queue.
        if (rd_pend_reg)
        begin
            q_reg[qcnt_reg[2:0]] <= ram_rdata;
        end

        case (state_reg)
            ST_AX_CHK:
            begin
                idx_reg[ax_reg] <= prod[32+IDX_W-1:32];
                wgt_reg[ax_reg] <= prod[31:16];
                if ((ax_reg == AXIS_Z) && !(ok_reg && ax_ok))
                begin
                    result_reg.sample_value <= '0;
                    result_reg.out_of_range <= 1'b1;
                end
            end
            ST_ROW_ADD:
            begin
                base_reg <= prod[ADDR_W-1:0] + ADDR_W'(idx_reg[AXIS_Y]);
            end
            ST_BASE_ADD:
            begin
                base_reg <= prod[ADDR_W-1:0] + ADDR_W'(idx_reg[AXIS_Z]);
            end
            ST_LERP_SUB:
            begin
                // Pop the two oldest entries: lo at the head, hi behind it.
                diff_reg <= $signed({q_reg[1][DATA_W-1], q_reg[1]})
                          - $signed({q_reg[0][DATA_W-1], q_reg[0]});
                lo_reg   <= q_reg[0];
                for (int n = 0; n < QUEUE_DEPTH - 2; n++)
                begin
                    q_reg[n] <= q_reg[n+2];
                end
            end
            ST_LERP_ADD:
            begin
                if (step_reg == LAST_STEP)
                begin
                    result_reg.sample_value <= blend_res;
                    result_reg.out_of_range <= 1'b0;
                end
                else
                begin
                    q_reg[qcnt_reg[2:0]] <= blend_res;
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    `TGS_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, $past(busy))
    `TGS_ASSERT_NEXT(a_write_no_stall, clk, rst_n, accept && (req.req_type == REQ_WRITE), !busy && !done)
    `TGS_ASSERT_NOW(a_oor_zero, clk, rst_n, done && result.out_of_range, result.sample_value == '0)
    `TGS_ASSERT_NOW(a_queue_full, clk, rst_n, (state_reg == ST_LERP_SUB) && (step_reg == '0), qcnt_reg == 4'(QUEUE_DEPTH))
    `TGS_ASSERT_NEXT(a_sample_busy, clk, rst_n, accept && (req.req_type == REQ_SAMPLE), busy && !done)

endmodule

@@ hw/rtl/tgs_mul.sv @@
// Shared registered signed multiplier of the trilinear grid sampler.
module tgs_mul (
    input  logic                                clk,
    input  logic signed [tgs_pkg::OPND_W-1:0]   op_a,
    input  logic signed [tgs_pkg::OPND_W-1:0]   op_b,
    output logic signed [tgs_pkg::PROD_W-1:0]   prod
);
    import tgs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/tgs_ram.sv @@
// Single-port grid memory with registered read data.
module tgs_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [31:0]       wdata,
    output logic [31:0]       rdata
);

    logic [31:0] mem [0:DEPTH-1];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/tgs_cfg.sv @@
// APB configuration registers of the trilinear grid sampler.
module tgs_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tgs_pkg::DATA_W-1:0]      pwdata,
    output logic [tgs_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output tgs_pkg::cfg_t                   cfg
);
    import tgs_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.offset_z      <= '0;
            cfg_reg.inv_cell_size <= INV_CELL_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OFFSET_X:      cfg_reg.offset_x      <= pwdata;
                REG_OFFSET_Y:      cfg_reg.offset_y      <= pwdata;
                REG_OFFSET_Z:      cfg_reg.offset_z      <= pwdata;
                REG_INV_CELL_SIZE: cfg_reg.inv_cell_size <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OFFSET_X:      prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:      prdata = cfg_reg.offset_y;
            REG_OFFSET_Z:      prdata = cfg_reg.offset_z;
            REG_INV_CELL_SIZE: prdata = cfg_reg.inv_cell_size;
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ dv/grid_sampler_scoreboard_pkg.sv @@
// Scoreboard class that predicts and checks trilinear grid sampler results.
`timescale 1ns / 1ps

package grid_sampler_scoreboard_pkg;

    import tgs_pkg::*;

    localparam int GRID_X      = 32;
    localparam int GRID_Y      = 32;
    localparam int GRID_Z      = 32;
    localparam int CELL_COUNT  = GRID_X * GRID_Y * GRID_Z;
    localparam int MAX_REPORTS = 10;

    class grid_sample_scoreboard;

        logic signed [DATA_W-1:0] cell_mem [CELL_COUNT];
        bit                       cell_written [CELL_COUNT];
        logic signed [DATA_W-1:0] offset [3];
        logic [DATA_W-1:0]        inv_cell_size;
        rsp_t                     expected_q [$];
        int                       mismatches;
        int                       results_checked;
        int                       oor_results;

        function new();
            offset[AXIS_X] = '0;
            offset[AXIS_Y] = '0;
            offset[AXIS_Z] = '0;
            inv_cell_size  = INV_CELL_RESET;
        endfunction

        function void set_register(logic [1:0] reg_index, logic [DATA_W-1:0] value);
            case (reg_index)
                REG_OFFSET_X:      offset[AXIS_X] = value;
                REG_OFFSET_Y:      offset[AXIS_Y] = value;
                REG_OFFSET_Z:      offset[AXIS_Z] = value;
                REG_INV_CELL_SIZE: inv_cell_size  = value;
                default: ;
            endcase
        endfunction

        function int cell_index(int unsigned i, int unsigned j, int unsigned k);
            return (i * GRID_Y + j) * GRID_Z + k;
        endfunction

        // Scale one axis; returns 1 when the base index leaves room for the upper corner.
        function bit split_axis(logic signed [DATA_W-1:0] pos, logic signed [DATA_W-1:0] off,
                                int cells, output int unsigned base, output longint weight);
            longint   shifted;
            bit [63:0] scaled;
            base    = 0;
            weight  = 0;
            shifted = longint'(pos) - longint'(off);
            if (shifted < 0)
                return 1'b0;
            scaled = shifted;
            scaled = scaled * {32'd0, inv_cell_size};
            base   = scaled[63:32];
            weight = scaled[31:16];
            return scaled[63:32] <= cells - 2;
        endfunction

        function bit locate(input req_t q, output int unsigned ix, iy, iz,
                            output longint wx, wy, wz);
            bit ok_x;
            bit ok_y;
            bit ok_z;
            ok_x = split_axis(q.pos_x, offset[AXIS_X], GRID_X, ix, wx);
            ok_y = split_axis(q.pos_y, offset[AXIS_Y], GRID_Y, iy, wy);
            ok_z = split_axis(q.pos_z, offset[AXIS_Z], GRID_Z, iz, wz);
            return ok_x && ok_y && ok_z;
        endfunction

        // Round to nearest, ties up: an arithmetic shift floors the biased product.
        function longint blend(longint a, longint b, longint w);
            longint q;
            q = (b - a) * w + 32768;
            return a + (q >>> 16);
        endfunction

        function longint stored(int unsigned i, int unsigned j, int unsigned k);
            return longint'(cell_mem[cell_index(i, j, k)]);
        endfunction

        function void note_item(req_t q);
            int unsigned ix, iy, iz;
            longint      wx, wy, wz;
            longint      along_z [2][2];
            longint      y0, y1, v;
            rsp_t        predicted;
            if (q.req_type == REQ_WRITE)
            begin
                cell_mem[q.cell_address]     = q.cell_value;
                cell_written[q.cell_address] = 1'b1;
                return;
            end
            if (!locate(q, ix, iy, iz, wx, wy, wz))
            begin
                predicted.sample_value = '0;
                predicted.out_of_range = 1'b1;
            end
            else
            begin
                for (int a = 0; a < 2; a++)
                    for (int b = 0; b < 2; b++)
                        along_z[a][b] = blend(stored(ix + a, iy + b, iz),
                                              stored(ix + a, iy + b, iz + 1), wz);
                y0 = blend(along_z[0][0], along_z[0][1], wy);
                y1 = blend(along_z[1][0], along_z[1][1], wy);
                v  = blend(y0, y1, wx);
                predicted.sample_value = v[DATA_W-1:0];
                predicted.out_of_range = 1'b0;
            end
            expected_q.push_back(predicted);
        endfunction

        function void compare_field(string field, logic signed [DATA_W-1:0] want,
                                    logic signed [DATA_W-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: %s differs: expected %0d, got %0d", $realtime, field,
                             want, got);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result %0d / %0b with no query pending", $realtime,
                             got.sample_value, got.out_of_range);
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (want.out_of_range)
                oor_results++;
            compare_field("sample_value", want.sample_value, got.sample_value);
            compare_field("out_of_range", want.out_of_range, got.out_of_range);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

@@ dv/testbench.sv @@
// Top-level testbench for the trilinear grid sampler: stimulus, APB setup and checking.
`timescale 1ns / 1ps

module testbench;

    import tgs_pkg::*;
    import grid_sampler_scoreboard_pkg::*;

    localparam int TARGET_ITEMS   = 750;
    localparam int QUERIES_PER_SET = 30;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 64;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    req_t                  req     = '0;
    logic                  done;
    rsp_t                  result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]     pwdata  = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    grid_sample_scoreboard sb;
    int                    items_sent;
    int                    settings_used;
    int                    quiet_cycles;
    bit                    gaps_on;

    trilinear_grid_sampler #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Check every strobed result against the oldest prediction, and end the run
    // if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if ((start && !busy) || done || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Mostly full-range values, with the extremes and small magnitudes mixed in
    // so that blends see both huge and tiny differences.
    function automatic logic signed [DATA_W-1:0] random_cell_value();
        case ($urandom_range(9, 0))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(32'h0002_0000, 0) - 32'h0001_0000;
            default: return $urandom();
        endcase
    endfunction

    // Set the kind, then fill every other field with noise; unused fields stay random.
    function automatic req_t random_req(logic kind);
        req_t q;
        q.req_type     = kind;
        q.cell_address = CELL_ADDR_W'($urandom());
        q.cell_value   = $urandom();
        q.pos_x        = $urandom();
        q.pos_y        = $urandom();
        q.pos_z        = $urandom();
        return q;
    endfunction

    function automatic logic signed [DATA_W-1:0] clip_pos(longint p);
        if (p > 64'sd2147483647 || p < -64'sd2147483648)
            return $urandom();
        return p[DATA_W-1:0];
    endfunction

    // Work backward from a wanted base index and fraction to a world position.
    // The top index is limited by how far the scale can reach from the offset.
    function automatic logic signed [DATA_W-1:0] in_range_pos(logic signed [DATA_W-1:0] off,
                                                              logic [DATA_W-1:0] inv,
                                                              int cells, bit at_top);
        bit [63:0]   reach;
        bit [63:0]   target;
        bit [63:0]   shifted;
        int unsigned top;
        int unsigned base;
        reach = 64'hFFFF_FFFF * {32'd0, inv};
        top   = reach[63:32];
        if (top > cells - 2)
            top = cells - 2;
        base    = at_top ? top : $urandom_range(top, 0);
        target  = {base, at_top ? 32'hFFFF_FFFF : 32'($urandom())};
        shifted = target / {32'd0, inv};
        return clip_pos(longint'(off) + longint'(shifted));
    endfunction

    // Positions on the border of the grid: the top valid cell, the origin itself,
    // one step below the origin, and the first cell past the end.
    function automatic logic signed [DATA_W-1:0] border_pos(logic signed [DATA_W-1:0] off,
                                                            logic [DATA_W-1:0] inv,
                                                            int cells);
        bit [63:0] target;
        bit [63:0] shifted;
        case ($urandom_range(3, 0))
            0: return in_range_pos(off, inv, cells, 1'b1);
            1: return off;
            2: return clip_pos(longint'(off) - 1);
            default:
            begin
                target  = {32'(cells - 1), 32'($urandom())};
                shifted = (target + {32'd0, inv} - 1) / {32'd0, inv};
                return clip_pos(longint'(off) + longint'(shifted));
            end
        endcase
    endfunction

    // Hold the sender off for a random stretch: usually none, sometimes a few
    // cycles, rarely a long pause.
    task automatic idle_gap();
        int roll;
        int cycles;
        roll = $urandom_range(99, 0);
        if (!gaps_on || roll < 60)
            return;
        cycles = (roll < 95) ? $urandom_range(4, 1) : $urandom_range(60, 15);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_item(req_t q);
        req   <= q;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(q);
        items_sent++;
        idle_gap();
    endtask

    task automatic write_cell(int unsigned addr, logic signed [DATA_W-1:0] value);
        req_t q;
        q              = random_req(REQ_WRITE);
        q.cell_address = CELL_ADDR_W'(addr);
        q.cell_value   = value;
        send_item(q);
    endtask

    // Load any corner the query would read that was never written, then send
    // the query itself.
    task automatic query_at(logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
                            logic signed [DATA_W-1:0] pz);
        req_t        q;
        int unsigned ix, iy, iz;
        longint      wx, wy, wz;
        int          addr;
        q       = random_req(REQ_SAMPLE);
        q.pos_x = px;
        q.pos_y = py;
        q.pos_z = pz;
        if (sb.locate(q, ix, iy, iz, wx, wy, wz))
            for (int corner = 0; corner < 8; corner++)
            begin
                addr = sb.cell_index(ix + corner[2], iy + corner[1], iz + corner[0]);
                if (!sb.cell_written[addr])
                    write_cell(addr, random_cell_value());
            end
        send_item(q);
    endtask

    // Drop start and wait until every query has answered, plus a few cycles for
    // trailing writes to land.
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read back of the same register.
    task automatic reg_write(logic [1:0] reg_index, logic [DATA_W-1:0] value);
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(reg_index, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.compare_field("register readback", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(logic [DATA_W-1:0] ox, logic [DATA_W-1:0] oy,
                                 logic [DATA_W-1:0] oz, logic [DATA_W-1:0] inv);
        wait_drained();
        reg_write(REG_OFFSET_X, ox);
        reg_write(REG_OFFSET_Y, oy);
        reg_write(REG_OFFSET_Z, oz);
        reg_write(REG_INV_CELL_SIZE, inv);
        settings_used++;
    endtask

    function automatic logic [DATA_W-1:0] random_offset();
        if ($urandom_range(3, 0) == 0)
            return $urandom();
        return ($urandom() & 32'h00FF_FFFF) - 32'h0080_0000;
    endfunction

    function automatic logic [DATA_W-1:0] random_scale();
        if ($urandom_range(1, 0) == 0)
            return $urandom_range(32'h0010_0000, 32'h0000_1000);
        return $urandom_range(32'hFFFF_FFFF, 1);
    endfunction

    // Directed items at the reset setting: extreme corner values, exact cell
    // hits, full and half weights, and each way a query falls off the grid.
    task automatic directed_items();
        for (int corner = 0; corner < 8; corner++)
            write_cell(sb.cell_index(corner[2], corner[1], corner[0]),
                       (corner[0] ^ corner[1] ^ corner[2]) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        query_at(32'sd0, 32'sd0, 32'sd0);
        query_at(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        query_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        query_at(-32'sd1, 32'sd0, 32'sd0);
        query_at(32'sd0, 32'(GRID_Y - 1) << 16, 32'sd0);
        query_at(32'sd0, 32'sd0, 32'h7FFF_FFFF);
        query_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        write_cell(CELL_COUNT - 1, 32'h7FFF_FFFF);
        query_at(32'(GRID_X - 2) << 16 | 32'h0000_FFFF, 32'(GRID_Y - 2) << 16 | 32'h0000_FFFF,
                 32'(GRID_Z - 2) << 16 | 32'h0000_FFFF);
    endtask

    // One random sequence: mostly well-formed in-range queries (with their
    // corners loaded first), plus loose writes, wild positions and border cases.
    task automatic random_sequence();
        int roll;
        int axis;
        logic signed [DATA_W-1:0] p [3];
        roll = $urandom_range(99, 0);
        if (roll >= 60 && roll < 75)
        begin
            write_cell(($urandom_range(1, 0) == 0) ? $urandom_range(2047, 0)
                                                   : $urandom_range(CELL_COUNT - 1, 0),
                       random_cell_value());
            return;
        end
        p[AXIS_X] = in_range_pos(sb.offset[AXIS_X], sb.inv_cell_size, GRID_X, 1'b0);
        p[AXIS_Y] = in_range_pos(sb.offset[AXIS_Y], sb.inv_cell_size, GRID_Y, 1'b0);
        p[AXIS_Z] = in_range_pos(sb.offset[AXIS_Z], sb.inv_cell_size, GRID_Z, 1'b0);
        if (roll >= 75 && roll < 85)
        begin
            p[AXIS_X] = $urandom();
            p[AXIS_Y] = $urandom();
            p[AXIS_Z] = $urandom();
        end
        else if (roll >= 85)
        begin
            axis    = $urandom_range(2, 0);
            p[axis] = border_pos(sb.offset[axis], sb.inv_cell_size, GRID_X);
        end
        query_at(p[AXIS_X], p[AXIS_Y], p[AXIS_Z]);
    endtask

    initial
    begin
        int set_no;
        logic [DATA_W-1:0] corner_off;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs back to back at the reset register values.
        gaps_on = 1'b0;
        directed_items();

        // Random part: walk through register settings, extremes first. Every
        // setting change waits for all outstanding queries to answer.
        set_no = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case (set_no)
                0: apply_setting(32'd0, 32'd0, 32'd0, INV_CELL_RESET);
                1: apply_setting(-(32'sd5 <<< 16), 32'sd3 <<< 16, -(32'sd1 <<< 20),
                                 32'h0002_0000);
                2: apply_setting(random_offset(), random_offset(), random_offset(), 32'd1);
                3: apply_setting(32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
                4: apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, INV_CELL_RESET);
                5:
                begin
                    corner_off = 32'h7FFF_FFFF;
                    apply_setting(corner_off, corner_off, corner_off, random_scale());
                end
                default: apply_setting(random_offset(), random_offset(), random_offset(),
                                       random_scale());
            endcase
            // Leave every fourth setting free of sender gaps.
            gaps_on = (set_no % 4 != 2);
            // Stop mid-setting once the item budget is spent.
            for (int n = 0; n < QUERIES_PER_SET && items_sent < TARGET_ITEMS; n++)
                random_sequence();
            set_no++;
        end

        // Let everything drain, then watch a while longer for stray strobes.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d items over %0d register settings", items_sent,
                 settings_used);
        $display("checked %0d query results, %0d of them off the grid",
                 sb.results_checked, sb.oor_results);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
